/* rtl/aescbc_pkg.sv */
// Shared types, tables and round functions for the AES-256 CBC block.
`default_nettype none
package aescbc_pkg;

  localparam int MAX_ROUNDS = 14;
  localparam int KEY_WORDS  = 8;
  localparam int RK_ROWS    = MAX_ROUNDS + 1;

  typedef logic [0:255][7:0] byte_tab_t;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        result_last;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_KEY_HIGH      = 3'd0,
    REG_KEY_UPPER_MID = 3'd1,
    REG_KEY_LOWER_MID = 3'd2,
    REG_KEY_LOW       = 3'd3,
    REG_IV_HIGH       = 3'd4,
    REG_IV_LOW        = 3'd5,
    REG_ROUND_COUNT   = 3'd6,
    REG_DECRYPT_MODE  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic       capture;
    logic       exp_step;
    logic       exp_last;
    logic [5:0] exp_idx;
    logic [3:0] rd_addr;
    logic       init;
    logic       round;
    logic       last_rnd;
    logic       finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic       keys_valid;
    logic       decrypt;
    logic [3:0] rounds;
    logic       out_free;
  } ctl_status_t;

  localparam byte_tab_t SBOX = {
    8'd99,8'd124,8'd119,8'd123,8'd242,8'd107,8'd111,8'd197,8'd48,8'd1,8'd103,8'd43,
    8'd254,8'd215,8'd171,8'd118,8'd202,8'd130,8'd201,8'd125,8'd250,8'd89,8'd71,8'd240,
    8'd173,8'd212,8'd162,8'd175,8'd156,8'd164,8'd114,8'd192,8'd183,8'd253,8'd147,8'd38,
    8'd54,8'd63,8'd247,8'd204,8'd52,8'd165,8'd229,8'd241,8'd113,8'd216,8'd49,8'd21,
    8'd4,8'd199,8'd35,8'd195,8'd24,8'd150,8'd5,8'd154,8'd7,8'd18,8'd128,8'd226,
    8'd235,8'd39,8'd178,8'd117,8'd9,8'd131,8'd44,8'd26,8'd27,8'd110,8'd90,8'd160,
    8'd82,8'd59,8'd214,8'd179,8'd41,8'd227,8'd47,8'd132,8'd83,8'd209,8'd0,8'd237,
    8'd32,8'd252,8'd177,8'd91,8'd106,8'd203,8'd190,8'd57,8'd74,8'd76,8'd88,8'd207,
    8'd208,8'd239,8'd170,8'd251,8'd67,8'd77,8'd51,8'd133,8'd69,8'd249,8'd2,8'd127,
    8'd80,8'd60,8'd159,8'd168,8'd81,8'd163,8'd64,8'd143,8'd146,8'd157,8'd56,8'd245,
    8'd188,8'd182,8'd218,8'd33,8'd16,8'd255,8'd243,8'd210,8'd205,8'd12,8'd19,8'd236,
    8'd95,8'd151,8'd68,8'd23,8'd196,8'd167,8'd126,8'd61,8'd100,8'd93,8'd25,8'd115,
    8'd96,8'd129,8'd79,8'd220,8'd34,8'd42,8'd144,8'd136,8'd70,8'd238,8'd184,8'd20,
    8'd222,8'd94,8'd11,8'd219,8'd224,8'd50,8'd58,8'd10,8'd73,8'd6,8'd36,8'd92,
    8'd194,8'd211,8'd172,8'd98,8'd145,8'd149,8'd228,8'd121,8'd231,8'd200,8'd55,8'd109,
    8'd141,8'd213,8'd78,8'd169,8'd108,8'd86,8'd244,8'd234,8'd101,8'd122,8'd174,8'd8,
    8'd186,8'd120,8'd37,8'd46,8'd28,8'd166,8'd180,8'd198,8'd232,8'd221,8'd116,8'd31,
    8'd75,8'd189,8'd139,8'd138,8'd112,8'd62,8'd181,8'd102,8'd72,8'd3,8'd246,8'd14,
    8'd97,8'd53,8'd87,8'd185,8'd134,8'd193,8'd29,8'd158,8'd225,8'd248,8'd152,8'd17,
    8'd105,8'd217,8'd142,8'd148,8'd155,8'd30,8'd135,8'd233,8'd206,8'd85,8'd40,8'd223,
    8'd140,8'd161,8'd137,8'd13,8'd191,8'd230,8'd66,8'd104,8'd65,8'd153,8'd45,8'd15,
    8'd176,8'd84,8'd187,8'd22
  };

  function automatic byte_tab_t build_inv();
    byte_tab_t t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam byte_tab_t INV_SBOX = build_inv();

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b_in);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] p;
    a = a_in;
    b = b_in;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p = p ^ a;
      a = xtime(a);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] v, input logic inv);
    logic [127:0] o;
    for (int j = 0; j < 16; j++) begin
      o[127-8*j -: 8] = inv ? INV_SBOX[v[127-8*j -: 8]] : SBOX[v[127-8*j -: 8]];
    end
    return o;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] v, input logic inv);
    logic [127:0] o;
    int src;
    o = v;
    for (int r = 1; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
        o[127-8*(r+4*c) -: 8] = v[127-8*(r+4*src) -: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] v, input logic inv);
    logic [127:0] o;
    logic [3:0][7:0] m;
    logic [7:0] acc;
    m = inv ? {8'd9, 8'd13, 8'd11, 8'd14} : {8'd1, 8'd1, 8'd3, 8'd2};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gf_mul(m[(k + 4 - r) & 3], v[127-8*(4*c+k) -: 8]);
        end
        o[127-8*(4*c+r) -: 8] = acc;
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

/* rtl/aescbc_ctrl.sv */
// Sequencer for key expansion, cipher rounds and result hand-off.
`default_nettype none
module aescbc_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire aescbc_pkg::ctl_status_t status,
  output aescbc_pkg::ctl_cmd_t         cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXPAND = 6'b000010,
    S_LOAD   = 6'b000100,
    S_INIT   = 6'b001000,
    S_ROUND  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] exp_idx_r, exp_idx_nxt;
  logic [3:0] rnd_r, rnd_nxt;
  logic [3:0] rnd_step;
  logic       rnd_last;

  assign in_stall = (state_r != S_IDLE);
  assign rnd_step = status.decrypt ? rnd_r - 4'd1 : rnd_r + 4'd1;
  assign rnd_last = status.decrypt ? (rnd_r == 4'd0) : (rnd_r == status.rounds);

  always_comb begin
    state_nxt   = state_r;
    exp_idx_nxt = exp_idx_r;
    rnd_nxt     = rnd_r;
    cmd         = '0;
    cmd.exp_idx = exp_idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          exp_idx_nxt = '0;
          state_nxt   = status.keys_valid ? S_LOAD : S_EXPAND;
        end
      end
      S_EXPAND: begin
        cmd.exp_step = 1'b1;
        cmd.exp_last = (exp_idx_r == {status.rounds, 2'b11});
        exp_idx_nxt  = exp_idx_r + 6'd1;
        if (cmd.exp_last) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.rd_addr = status.decrypt ? status.rounds : 4'd0;
        rnd_nxt     = cmd.rd_addr;
        state_nxt   = S_INIT;
      end
      S_INIT: begin
        cmd.init    = 1'b1;
        cmd.rd_addr = rnd_step;
        rnd_nxt     = rnd_step;
        state_nxt   = S_ROUND;
      end
      S_ROUND: begin
        cmd.round    = 1'b1;
        cmd.last_rnd = rnd_last;
        if (rnd_last) begin
          cmd.rd_addr = rnd_r;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_addr = rnd_step;
          rnd_nxt     = rnd_step;
        end
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      exp_idx_r <= '0;
      rnd_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      exp_idx_r <= exp_idx_nxt;
      rnd_r     <= rnd_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/aescbc_dp.sv */
// Datapath: configuration, round key store, cipher state, chaining and output.
`default_nettype none
module aescbc_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [63:0]           cfg_data,
  input  wire aescbc_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output aescbc_pkg::out_item_t      out_data,
  input  wire aescbc_pkg::ctl_cmd_t  cmd,
  output aescbc_pkg::ctl_status_t    status
);

  logic [255:0]      key_r;
  logic [127:0]      iv_r;
  logic [3:0]        round_cnt_r;
  logic              decrypt_r;
  logic              keys_valid_r;
  logic [3:0]        rounds;

  logic [3:0][31:0]  rk_mem [aescbc_pkg::RK_ROWS];
  logic [127:0]      rk_q_r;

  logic [7:0][31:0]  win_r;
  logic [7:0]        rcon_r;
  logic [31:0]       exp_t;
  logic [31:0]       exp_word;

  logic [127:0]      blk_r;
  logic              last_r;
  logic [127:0]      chain_r;
  logic [127:0]      st_r, st_nxt;
  logic [127:0]      tmp;
  logic [127:0]      res;

  logic              out_valid_r;
  aescbc_pkg::out_item_t out_r;

  always_comb begin
    if (round_cnt_r == 4'd0) begin
      rounds = 4'd1;
    end else if (round_cnt_r > 4'(aescbc_pkg::MAX_ROUNDS)) begin
      rounds = 4'(aescbc_pkg::MAX_ROUNDS);
    end else begin
      rounds = round_cnt_r;
    end
  end

  assign status.keys_valid = keys_valid_r;
  assign status.decrypt    = decrypt_r;
  assign status.rounds     = rounds;
  assign status.out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r        <= '0;
      iv_r         <= '0;
      round_cnt_r  <= 4'(aescbc_pkg::MAX_ROUNDS);
      decrypt_r    <= 1'b0;
      keys_valid_r <= 1'b0;
    end else if (cfg_wr_en) begin
      keys_valid_r <= 1'b0;
      case (aescbc_pkg::cfg_reg_t'(cfg_index))
        aescbc_pkg::REG_KEY_HIGH:      key_r[255:192] <= cfg_data;
        aescbc_pkg::REG_KEY_UPPER_MID: key_r[191:128] <= cfg_data;
        aescbc_pkg::REG_KEY_LOWER_MID: key_r[127:64]  <= cfg_data;
        aescbc_pkg::REG_KEY_LOW:       key_r[63:0]    <= cfg_data;
        aescbc_pkg::REG_IV_HIGH:       iv_r[127:64]   <= cfg_data;
        aescbc_pkg::REG_IV_LOW:        iv_r[63:0]     <= cfg_data;
        aescbc_pkg::REG_ROUND_COUNT:   round_cnt_r    <= cfg_data[3:0];
        aescbc_pkg::REG_DECRYPT_MODE:  decrypt_r      <= cfg_data[0];
        default: ;
      endcase
    end else if (cmd.exp_step && cmd.exp_last) begin
      keys_valid_r <= 1'b1;
    end
  end

  // key schedule: one word per cycle, window holds the last eight words
  always_comb begin
    exp_t = win_r[7];
    if (cmd.exp_idx[2:0] == 3'd0) begin
      exp_t = aescbc_pkg::sub_word({win_r[7][23:0], win_r[7][31:24]}) ^ {rcon_r, 24'd0};
    end else if (cmd.exp_idx[2:0] == 3'd4) begin
      exp_t = aescbc_pkg::sub_word(win_r[7]);
    end
    if (cmd.exp_idx < 6'(aescbc_pkg::KEY_WORDS)) begin
      exp_word = key_r[255 - 32*cmd.exp_idx[2:0] -: 32];
    end else begin
      exp_word = win_r[0] ^ exp_t;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rcon_r <= 8'd1;
    end else if (cmd.exp_step) begin
      win_r <= {exp_word, win_r[7:1]};
      if (cmd.exp_idx >= 6'(aescbc_pkg::KEY_WORDS) && cmd.exp_idx[2:0] == 3'd0) begin
        rcon_r <= aescbc_pkg::xtime(rcon_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_step) begin
      rk_mem[cmd.exp_idx[5:2]][~cmd.exp_idx[1:0]] <= exp_word;
    end
    rk_q_r <= rk_mem[cmd.rd_addr];
  end

  // one cipher round per cycle
  always_comb begin
    st_nxt = st_r;
    tmp    = '0;
    if (cmd.init) begin
      st_nxt = (decrypt_r ? blk_r : blk_r ^ chain_r) ^ rk_q_r;
    end else if (cmd.round) begin
      if (decrypt_r) begin
        tmp = aescbc_pkg::sub_bytes(aescbc_pkg::shift_rows(st_r, 1'b1), 1'b1) ^ rk_q_r;
        st_nxt = cmd.last_rnd ? tmp : aescbc_pkg::mix_columns(tmp, 1'b1);
      end else begin
        tmp = aescbc_pkg::shift_rows(aescbc_pkg::sub_bytes(st_r, 1'b0), 1'b0);
        st_nxt = (cmd.last_rnd ? tmp : aescbc_pkg::mix_columns(tmp, 1'b0)) ^ rk_q_r;
      end
    end
  end

  assign res = decrypt_r ? (st_r ^ chain_r) : st_r;

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (cmd.capture) begin
      blk_r  <= {in_data.block_high, in_data.block_low};
      last_r <= in_data.last_block;
    end
    if (cmd.finish) begin
      out_r.result_high <= res[127:64];
      out_r.result_low  <= res[63:0];
      out_r.result_last <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (cmd.capture && !keys_valid_r) begin
      chain_r <= iv_r;
    end else if (cmd.finish) begin
      if (last_r) begin
        chain_r <= iv_r;
      end else begin
        chain_r <= decrypt_r ? blk_r : st_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* rtl/aes256_cbc_cipher_variable_rounds.sv */
// AES-256 CBC cipher with a programmable round count: top level.
// Input channel in_valid/in_stall/in_data carries one 128-bit block and a
// last-block flag; the result leaves on out_valid/out_stall/out_data, one
// result per block, in order. The cfg port writes the key, IV, round count
// and direction one 64-bit register per cycle; the user must write them only
// while the block is idle, which the block itself does not enforce. One block
// at a time: after acceptance a block fetches the first round key, then does
// the initial key addition, then each round in turn, then loads the output
// register once it is free; out_valid rises with that load. The next block
// is accepted only after the block has returned to idle.
// The first block after reset or after any register write first runs the key
// schedule, one 32-bit word per cycle, and restarts the chain from the IV.
// The chain also restarts after a last block.
// The round keys sit in a 15 x 128-bit store written one word a cycle and
// read one row a cycle; the single round unit sets the rate.
// Reset is synchronous: registers return to zero key and IV, 14 rounds,
// encrypt, keys pending. in_stall stays high while a block is in work; a
// finished result waits in the output register while out_stall is high,
// and the next block may be taken meanwhile.
`default_nettype none
module aes256_cbc_cipher_variable_rounds (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [63:0]           cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire aescbc_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output aescbc_pkg::out_item_t      out_data
);

  aescbc_pkg::ctl_cmd_t    cmd;
  aescbc_pkg::ctl_status_t status;

  aescbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  aescbc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block accepted a transfer but did not go busy");

  a_rk_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.init || cmd.round) |-> (cmd.rd_addr <= 4'(aescbc_pkg::MAX_ROUNDS)))
    else $error("round key address out of range");

  a_cfg_invalidates: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !status.keys_valid)
    else $error("register write did not mark keys pending");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> status.out_free)
    else $error("result loaded over an untaken result");

endmodule
`default_nettype wire
